>>> rtl/jslt_pkg.sv
// ----------------------------------------------------------------------------
// jslt_pkg
// Shared types and constants for the job slot lifecycle table.
// ----------------------------------------------------------------------------
`default_nettype none

package jslt_pkg;

  localparam int unsigned IdW = 32;
  localparam logic [2:0]  ActiveMax = 3'd7;

  typedef enum logic [2:0] {
    CMD_ENQUEUE = 3'd0,
    CMD_ADVANCE = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_PAUSE   = 3'd3,
    CMD_RESUME  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_SCOPE    = 3'd1,
    ST_DUP      = 3'd2,
    ST_RUN      = 3'd3,
    ST_APPROVAL = 3'd4,
    ST_DONE     = 3'd5,
    ST_FAILED   = 3'd6,
    ST_PAUSED   = 3'd7
  } stage_e;

  typedef struct packed {
    cmd_e           cmd;
    logic [IdW-1:0] job_id;
  } req_t;

  typedef struct packed {
    logic           ok;
    logic [IdW-1:0] assigned_id;
    stage_e         stage_after;
    logic [2:0]     jobs_active;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/job_slot_lifecycle_table.sv
// ----------------------------------------------------------------------------
// job_slot_lifecycle_table
// Result path: input register, then the slot lookup/update, in which all slots
//   compare and update at once, into the result register.
// Throughput: one request per cycle while the result is not stalled.
// Reset: all slots free, id counter at 1, no request or result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module job_slot_lifecycle_table #(
  parameter int unsigned SLOT_COUNT = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] job_id_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        ok_o,
  output logic [31:0] assigned_id_o,
  output logic [2:0]  stage_after_o,
  output logic [2:0]  jobs_active_o
);
  import jslt_pkg::*;

  logic req_vld_q, req_vld_d;
  req_t req_q;
  logic res_vld_q, res_vld_d;
  res_t res_q, res_d;
  logic fire, accept;

  assign fire        = req_vld_q && (!res_vld_q || !res_stall_i);
  assign req_stall_o = req_vld_q && !fire;
  assign accept      = req_valid_i && !req_stall_o;
  assign req_vld_d   = accept || (req_vld_q && !fire);
  assign res_vld_d   = fire || (res_vld_q && res_stall_i);

  jslt_slots #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slots (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .req_i (req_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      req_vld_q <= req_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.cmd    <= cmd_e'(command_i);
      req_q.job_id <= job_id_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o   = res_vld_q;
  assign ok_o          = res_q.ok;
  assign assigned_id_o = res_q.assigned_id;
  assign stage_after_o = res_q.stage_after;
  assign jobs_active_o = res_q.jobs_active;

endmodule

`default_nettype wire

>>> rtl/jslt_slots.sv
// ----------------------------------------------------------------------------
// jslt_slots
// Slot table state and the combinational update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module jslt_slots #(
  parameter int unsigned SLOT_COUNT = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  jslt_pkg::req_t req_i,
  output jslt_pkg::res_t res_o
);
  import jslt_pkg::*;

  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [IdW-1:0]        id_q [SLOT_COUNT];
  stage_e                stage_q [SLOT_COUNT];
  stage_e                stage_d [SLOT_COUNT];
  logic [IdW-1:0]        ctr_q, ctr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  logic [SLOT_COUNT-1:0] free, free_oh, match, hit_oh;
  logic [2:0]            hit_st, adv_st;
  logic [CntW+2:0]       cnt_ext;

  always_comb begin
    free    = ~used_q;
    // lowest set bit
    free_oh = free & (~free + SLOT_COUNT'(1));
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = used_q[i] && (id_q[i] == req_i.job_id);
    end
    hit_oh = match & (~match + SLOT_COUNT'(1));
    hit_st = 3'd0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (hit_oh[i]) begin
        hit_st = hit_st | stage_q[i];
      end
    end
    adv_st = hit_st + 3'd1;
  end

  always_comb begin
    used_d  = used_q;
    stage_d = stage_q;
    ctr_d   = ctr_q;
    cnt_d   = cnt_q;
    res_o.ok          = 1'b0;
    res_o.assigned_id = '0;
    res_o.stage_after = ST_QUEUED;
    case (req_i.cmd)
      CMD_ENQUEUE: begin
        if (|free) begin
          used_d = used_q | free_oh;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (free_oh[i]) begin
              stage_d[i] = ST_QUEUED;
            end
          end
          res_o.assigned_id = ctr_q;
          res_o.ok          = 1'b1;
          ctr_d = ctr_q + IdW'(1);
          cnt_d = cnt_q + CntW'(1);
        end
      end
      CMD_ADVANCE: begin
        if (|hit_oh) begin
          res_o.stage_after = stage_e'(hit_st);
          if (hit_st <= ST_APPROVAL) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (hit_oh[i]) begin
                stage_d[i] = stage_e'(adv_st);
              end
            end
            res_o.stage_after = stage_e'(adv_st);
            res_o.ok          = 1'b1;
          end
        end
      end
      CMD_RELEASE: begin
        if (|hit_oh) begin
          res_o.stage_after = stage_e'(hit_st);
          if (hit_st == ST_DONE || hit_st == ST_FAILED) begin
            used_d   = used_q & ~hit_oh;
            cnt_d    = cnt_q - CntW'(1);
            res_o.ok = 1'b1;
          end
        end
      end
      CMD_PAUSE: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (used_q[i] && stage_q[i] == ST_RUN) begin
            stage_d[i] = ST_PAUSED;
          end
        end
        res_o.ok = 1'b1;
      end
      CMD_RESUME: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (used_q[i] && stage_q[i] == ST_PAUSED) begin
            stage_d[i] = ST_RUN;
          end
        end
        res_o.ok = 1'b1;
      end
      default: begin
      end
    endcase
    // count saturates at the field maximum for large tables
    cnt_ext = {3'b000, cnt_d};
    if (cnt_ext > (CntW + 3)'(ActiveMax)) begin
      res_o.jobs_active = ActiveMax;
    end else begin
      res_o.jobs_active = cnt_ext[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      ctr_q  <= IdW'(1);
      cnt_q  <= '0;
    end else if (fire_i) begin
      used_q <= used_d;
      ctr_q  <= ctr_d;
      cnt_q  <= cnt_d;
    end
  end

  // slot payload is only read behind its used bit
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (req_i.cmd == CMD_ENQUEUE && free_oh[i]) begin
          id_q[i] <= ctr_q;
        end
        stage_q[i] <= stage_d[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/jslt_checker.sv
// ----------------------------------------------------------------------------
// jslt_checker
// Port-level checks for the job slot lifecycle table.
// ----------------------------------------------------------------------------
`default_nettype none

module jslt_checker #(
  parameter int unsigned SLOT_COUNT = 5
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic        res_stall_i,
  input logic        ok_o,
  input logic [31:0] assigned_id_o,
  input logic [2:0]  stage_after_o,
  input logic [2:0]  jobs_active_o
);
  import jslt_pkg::*;

  // held result must not change while stalled
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(ok_o)
      && $stable(assigned_id_o) && $stable(stage_after_o) && $stable(jobs_active_o))
    else $error("result changed while stalled");

  a_active_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> 32'(jobs_active_o) <= SLOT_COUNT)
    else $error("active count above slot count");

  // a refused request never hands out an id
  a_refused_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !ok_o |-> assigned_id_o == 32'd0)
    else $error("id reported on refused request");

  // an enqueue result always reports the queued stage
  a_enq_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && assigned_id_o != 32'd0 |-> ok_o && stage_after_o == ST_QUEUED)
    else $error("enqueue result inconsistent");

endmodule

bind job_slot_lifecycle_table jslt_checker #(
  .SLOT_COUNT(SLOT_COUNT)
) u_jslt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_o  (res_valid_o),
  .res_stall_i  (res_stall_i),
  .ok_o         (ok_o),
  .assigned_id_o(assigned_id_o),
  .stage_after_o(stage_after_o),
  .jobs_active_o(jobs_active_o)
);

`default_nettype wire
